### src/fmws_pkg.sv
// fmws_pkg: shared types, constants and saturation helpers for the face
// maximum wave-speed block. Used by fmws_unit, fmws_seq and face_max_wave_speed.
`default_nettype none

package fmws_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam logic [47:0] LIM = 48'hFFFF_FFFF_FFFF;
  localparam logic [17:0] GAMMA_RESET = 18'd91750;

  // operations of the shared arithmetic unit
  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_DIV  = 2'd1;
  localparam logic [1:0] OP_SQRT = 2'd2;

  typedef struct packed {
    logic        start;
    logic [1:0]  op;
    logic [63:0] a;
    logic [63:0] b;
  } unit_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef struct packed {
    logic        ovf;
    logic [47:0] val;
  } sat_t;

  // product shifted down, saturated to 48 bits
  function automatic sat_t mul_post(logic [127:0] prod, int sh);
    logic [63:0] r;
    sat_t        s;
    r = prod[63:0] >> sh;
    if (prod[127:64] != 64'd0 || r[63:48] != 16'd0) begin
      s.ovf = 1'b1;
      s.val = LIM;
    end else begin
      s.ovf = 1'b0;
      s.val = r[47:0];
    end
    return s;
  endfunction

  // quotient saturated to 48 bits
  function automatic sat_t div_post(logic [63:0] quo);
    sat_t s;
    if (quo[63:48] != 16'd0) begin
      s.ovf = 1'b1;
      s.val = LIM;
    end else begin
      s.ovf = 1'b0;
      s.val = quo[47:0];
    end
    return s;
  endfunction

  // true when num << sh no longer fits in 64 bits
  function automatic logic shl_ovf(logic [63:0] num, int sh);
    return (num >> (64 - sh)) != 64'd0;
  endfunction

endpackage

`default_nettype wire

### src/fmws_unit.sv
// fmws_unit: shared iterative arithmetic unit: 64x64 multiply in 16-bit digits,
// 64/32 restoring divide and 64-bit integer square root, one step per cycle.
// Depends on fmws_pkg.
`default_nettype none

module fmws_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire fmws_pkg::unit_ctl_t ctl,
  output fmws_pkg::unit_stat_t    stat,
  output logic [127:0]            result
);

  logic         busy;
  logic         done;
  logic [1:0]   op;
  logic [5:0]   cnt;
  logic [63:0]  a;
  logic [63:0]  b;
  logic [127:0] acc;
  logic [35:0]  rem;
  logic [63:0]  quo;

  logic [79:0]  pp;
  logic [32:0]  drem;
  logic         dge;
  logic [35:0]  srem;
  logic [35:0]  trial;
  logic         sge;

  assign pp    = a * b[63:48];
  assign drem  = {rem[31:0], a[63]};
  assign dge   = drem >= {1'b0, b[31:0]};
  assign srem  = {rem[33:0], a[63:62]};
  assign trial = {2'b00, quo[31:0], 2'b01};
  assign sge   = srem >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        op   <= ctl.op;
        a    <= ctl.a;
        b    <= ctl.b;
        acc  <= '0;
        rem  <= '0;
        quo  <= '0;
        unique case (ctl.op)
          fmws_pkg::OP_MUL:  cnt <= 6'd3;
          fmws_pkg::OP_DIV:  cnt <= 6'd63;
          default:           cnt <= 6'd31;
        endcase
      end else if (busy) begin
        unique case (op)
          fmws_pkg::OP_MUL: begin
            acc <= {acc[111:0], 16'd0} + {48'd0, pp};
            b   <= {b[47:0], 16'd0};
          end
          fmws_pkg::OP_DIV: begin
            rem <= dge ? {3'd0, drem - {1'b0, b[31:0]}} : {3'd0, drem};
            quo <= {quo[62:0], dge};
            a   <= {a[62:0], 1'b0};
          end
          default: begin
            rem <= sge ? srem - trial : srem;
            quo <= {quo[62:0], sge};
            a   <= {a[61:0], 2'b00};
          end
        endcase
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    unique case (op)
      fmws_pkg::OP_MUL: result = acc;
      fmws_pkg::OP_DIV: result = {64'd0, quo};
      default:          result = {96'd0, quo[31:0]};
    endcase
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

### src/fmws_seq.sv
// fmws_seq: sequencer for one node and the face result; keeps the running
// maxima and drives fmws_unit. Depends on fmws_pkg.
`default_nettype none

module fmws_seq #(
  parameter int FRAC_BITS = fmws_pkg::FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [17:0]          gamma_ratio,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic signed [31:0]   density,
  input  wire logic signed [31:0]   mom_x,
  input  wire logic signed [31:0]   mom_y,
  input  wire logic signed [31:0]   mom_z,
  input  wire logic signed [31:0]   energy,
  input  wire logic signed [31:0]   face_scale,
  input  wire logic                 last_node,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [30:0]               max_speed,
  output logic signed [31:0]        scaled_speed,
  output logic                      range_fault,
  output fmws_pkg::unit_ctl_t       ctl,
  input  wire fmws_pkg::unit_stat_t stat,
  input  wire logic [127:0]         result
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIVQ = 4'd1;
  localparam logic [3:0] S_SQQ  = 4'd2;
  localparam logic [3:0] S_KE   = 4'd3;
  localparam logic [3:0] S_P    = 4'd4;
  localparam logic [3:0] S_GP   = 4'd5;
  localparam logic [3:0] S_C2   = 4'd6;
  localparam logic [3:0] S_PEAK = 4'd7;
  localparam logic [3:0] S_SQV  = 4'd8;
  localparam logic [3:0] S_SQC  = 4'd9;
  localparam logic [3:0] S_SCL  = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;

  localparam logic [25:0] ONE = 26'd1 << FRAC_BITS;
  localparam logic [63:0] SQ_PAD = (64'd1 << FRAC_BITS) - 64'd1;

  logic [3:0]         state;
  logic [31:0]        rho;
  logic [31:0]        mag [3];
  logic signed [31:0] e;
  logic [31:0]        fs_mag;
  logic               fs_neg;
  logic               last;
  logic [1:0]         k;
  logic [49:0]        v2;
  logic [47:0]        c2;
  logic               f;
  logic               fault_seen;
  logic [47:0]        peak_v;
  logic [47:0]        peak_c;
  logic [31:0]        sv;
  logic [30:0]        s_sat;
  logic               flt;
  logic [31:0]        scl;

  // 32-bit two's complement magnitude
  function automatic logic [31:0] mag32(logic [31:0] raw);
    return raw[31] ? (~raw + 32'd1) : raw;
  endfunction

  // radicand with fraction pad, all ones when it no longer fits
  function automatic logic [63:0] sq_arg(logic [47:0] x);
    if (fmws_pkg::shl_ovf({16'd0, x}, FRAC_BITS)) begin
      return '1;
    end
    return ({16'd0, x} << FRAC_BITS) | SQ_PAD;
  endfunction

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin : seq_ff
    logic [31:0]        m;
    fmws_pkg::sat_t     sr;
    logic [49:0]        vsum;
    logic [47:0]        vs;
    logic signed [49:0] d;
    logic [49:0]        ad;
    logic [25:0]        g1;
    logic [47:0]        pv;
    logic [47:0]        pc;
    logic [32:0]        s;
    logic [63:0]        prod;
    if (rst) begin
      state      <= S_IDLE;
      ctl.start  <= 1'b0;
      out_valid  <= 1'b0;
      fault_seen <= 1'b0;
      peak_v     <= '0;
      peak_c     <= '0;
    end else begin
      ctl.start <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            rho    <= density;
            mag[0] <= mag32(mom_x);
            mag[1] <= mag32(mom_y);
            mag[2] <= mag32(mom_z);
            e      <= energy;
            fs_mag <= mag32(face_scale);
            fs_neg <= face_scale[31];
            last   <= last_node;
            k      <= 2'd0;
            if (density == 32'sd0 || density[31]) begin
              f     <= 1'b1;
              v2    <= {2'b00, fmws_pkg::LIM};
              c2    <= fmws_pkg::LIM;
              state <= S_PEAK;
            end else begin
              // momentum magnitude < 2^32, so the shifted dividend fits for FRAC_BITS <= 32
              f      <= 1'b0;
              v2     <= '0;
              m      = mag32(mom_x);
              ctl.start <= 1'b1;
              ctl.op    <= fmws_pkg::OP_DIV;
              ctl.a     <= {32'd0, m} << FRAC_BITS;
              ctl.b     <= {32'd0, density};
              state     <= S_DIVQ;
            end
          end
        end
        S_DIVQ: begin
          if (stat.done) begin
            sr = fmws_pkg::div_post(result[63:0]);
            if (sr.ovf) begin
              f <= 1'b1;
            end
            ctl.start <= 1'b1;
            ctl.op    <= fmws_pkg::OP_MUL;
            ctl.a     <= {16'd0, sr.val};
            ctl.b     <= {16'd0, sr.val};
            state     <= S_SQQ;
          end
        end
        S_SQQ: begin
          if (stat.done) begin
            sr = fmws_pkg::mul_post(result, FRAC_BITS);
            vsum = v2 + {2'b00, sr.val};
            if (sr.ovf) begin
              f <= 1'b1;
            end
            if (k == 2'd2) begin
              if (vsum > {2'b00, fmws_pkg::LIM}) begin
                vs = fmws_pkg::LIM;
                f  <= 1'b1;
              end else begin
                vs = vsum[47:0];
              end
              v2        <= {2'b00, vs};
              ctl.start <= 1'b1;
              ctl.op    <= fmws_pkg::OP_MUL;
              ctl.a     <= {32'd0, rho};
              ctl.b     <= {16'd0, vs};
              state     <= S_KE;
            end else begin
              v2        <= vsum;
              k         <= k + 2'd1;
              ctl.start <= 1'b1;
              ctl.op    <= fmws_pkg::OP_DIV;
              ctl.a     <= {32'd0, mag[k + 2'd1]} << FRAC_BITS;
              ctl.b     <= {32'd0, rho};
              state     <= S_DIVQ;
            end
          end
        end
        S_KE: begin
          if (stat.done) begin
            sr = fmws_pkg::mul_post(result, FRAC_BITS + 1);
            if (sr.ovf) begin
              f <= 1'b1;
            end
            d  = 50'(e) - $signed({2'b00, sr.val});
            ad = d[49] ? 50'(-d) : 50'(d);
            g1 = ({8'd0, gamma_ratio} >= ONE) ? ({8'd0, gamma_ratio} - ONE)
                                              : (ONE - {8'd0, gamma_ratio});
            ctl.start <= 1'b1;
            ctl.op    <= fmws_pkg::OP_MUL;
            ctl.a     <= {38'd0, g1};
            ctl.b     <= {14'd0, ad};
            state     <= S_P;
          end
        end
        S_P: begin
          if (stat.done) begin
            sr = fmws_pkg::mul_post(result, FRAC_BITS);
            if (sr.ovf) begin
              f <= 1'b1;
            end
            ctl.start <= 1'b1;
            ctl.op    <= fmws_pkg::OP_MUL;
            ctl.a     <= {46'd0, gamma_ratio};
            ctl.b     <= {16'd0, sr.val};
            state     <= S_GP;
          end
        end
        S_GP: begin
          if (stat.done) begin
            sr = fmws_pkg::mul_post(result, FRAC_BITS);
            if (sr.ovf) begin
              f <= 1'b1;
            end
            if (fmws_pkg::shl_ovf({16'd0, sr.val}, FRAC_BITS)) begin
              f     <= 1'b1;
              c2    <= fmws_pkg::LIM;
              state <= S_PEAK;
            end else begin
              ctl.start <= 1'b1;
              ctl.op    <= fmws_pkg::OP_DIV;
              ctl.a     <= {16'd0, sr.val} << FRAC_BITS;
              ctl.b     <= {32'd0, rho};
              state     <= S_C2;
            end
          end
        end
        S_C2: begin
          if (stat.done) begin
            sr = fmws_pkg::div_post(result[63:0]);
            if (sr.ovf) begin
              f <= 1'b1;
            end
            c2    <= sr.val;
            state <= S_PEAK;
          end
        end
        S_PEAK: begin
          pv = (v2[47:0] > peak_v) ? v2[47:0] : peak_v;
          pc = (c2 > peak_c) ? c2 : peak_c;
          peak_v <= pv;
          peak_c <= pc;
          if (f) begin
            fault_seen <= 1'b1;
          end
          if (last) begin
            ctl.start <= 1'b1;
            ctl.op    <= fmws_pkg::OP_SQRT;
            ctl.a     <= sq_arg(pv);
            ctl.b     <= '0;
            state     <= S_SQV;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SQV: begin
          if (stat.done) begin
            sv        <= result[31:0];
            ctl.start <= 1'b1;
            ctl.op    <= fmws_pkg::OP_SQRT;
            ctl.a     <= sq_arg(peak_c);
            ctl.b     <= '0;
            state     <= S_SQC;
          end
        end
        S_SQC: begin
          if (stat.done) begin
            s = {1'b0, sv} + {1'b0, result[31:0]};
            if (s > 33'h07FFF_FFFF) begin
              s   = 33'h07FFF_FFFF;
              flt <= 1'b1;
            end else begin
              flt <= fault_seen;
            end
            s_sat     <= s[30:0];
            ctl.start <= 1'b1;
            ctl.op    <= fmws_pkg::OP_MUL;
            ctl.a     <= {31'd0, s};
            ctl.b     <= {32'd0, fs_mag};
            state     <= S_SCL;
          end
        end
        S_SCL: begin
          if (stat.done) begin
            prod = result[63:0] >> FRAC_BITS;
            if (fs_neg) begin
              if (prod > 64'h8000_0000) begin
                prod = 64'h8000_0000;
                flt  <= 1'b1;
              end
              scl <= 32'(64'd0 - prod);
            end else begin
              if (prod > 64'h7FFF_FFFF) begin
                prod = 64'h7FFF_FFFF;
                flt  <= 1'b1;
              end
              scl <= prod[31:0];
            end
            state <= S_FIN;
          end
        end
        S_FIN: begin
          // hold until the previous result has been transferred
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            max_speed    <= s_sat;
            scaled_speed <= scl;
            range_fault  <= flt;
            peak_v       <= '0;
            peak_c       <= '0;
            fault_seen   <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while node in progress");

  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    ctl.start |-> !stat.busy)
    else $error("unit started while busy");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FIN))
    else $error("result raised outside finish step");

  a_done_not_idle: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> state != S_IDLE)
    else $error("unit finished with no operation pending");

endmodule

`default_nettype wire

### src/face_max_wave_speed.sv
// face_max_wave_speed: top level; holds the gamma register and ties the
// sequencer to the shared arithmetic unit. Depends on fmws_pkg, fmws_unit, fmws_seq.
//
// Usage:
//   Nodes of a face arrive on the input channel (in_valid/in_ready), one
//   transfer per node, with the five conserved variables, the face scale and
//   last_node. A node with last_node low gives no result; the last node of a
//   face gives one result on the output channel (out_valid/out_ready).
//   Each node is worked through one shared iterative unit: four 64-step
//   divisions (the last skipped on overflow) and six 4-step multiplies;
//   a node with non-positive density skips the arithmetic. The last node
//   adds two 32-step square roots and a multiply before its result is
//   valid. in_ready is high only between nodes. gamma_ratio is written
//   through cfg_we/cfg_wdata while the block is idle; the block itself
//   does not enforce this.
//   The result sits in an output register; the next node is taken while it
//   waits, and a stalled receiver only holds the block at the end of the
//   following face. Reset (rst, synchronous) clears the running maxima, the
//   fault flag and the output valid, and sets gamma_ratio to 1.4.
`default_nettype none

module face_max_wave_speed #(
  parameter int FRAC_BITS = fmws_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [17:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] density,
  input  wire logic signed [31:0] mom_x,
  input  wire logic signed [31:0] mom_y,
  input  wire logic signed [31:0] mom_z,
  input  wire logic signed [31:0] energy,
  input  wire logic signed [31:0] face_scale,
  input  wire logic               last_node,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [30:0]             max_speed,
  output logic signed [31:0]      scaled_speed,
  output logic                    range_fault
);

  logic                 [17:0] gamma_ratio;
  fmws_pkg::unit_ctl_t  ctl;
  fmws_pkg::unit_stat_t stat;
  logic [127:0]         result;

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma_ratio <= fmws_pkg::GAMMA_RESET;
    end else if (cfg_we) begin
      gamma_ratio <= cfg_wdata;
    end
  end

  fmws_unit u_unit (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .stat   (stat),
    .result (result)
  );

  fmws_seq #(
    .FRAC_BITS (FRAC_BITS)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .gamma_ratio  (gamma_ratio),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .density      (density),
    .mom_x        (mom_x),
    .mom_y        (mom_y),
    .mom_z        (mom_z),
    .energy       (energy),
    .face_scale   (face_scale),
    .last_node    (last_node),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .max_speed    (max_speed),
    .scaled_speed (scaled_speed),
    .range_fault  (range_fault),
    .ctl          (ctl),
    .stat         (stat),
    .result       (result)
  );

endmodule

`default_nettype wire

### test/tb_top.sv
// tb_top: self-checking testbench for face_max_wave_speed.
// Drives nodes over valid/ready, predicts face results in SV and checks each
// transfer on the output channel. Depends on fmws_pkg and the block's RTL.
`default_nettype none

module tb_top;

  localparam int FB = 16;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 1500;
  localparam int DRAIN_CYCLES = 500;

  typedef struct {
    logic [30:0]        spd;
    logic signed [31:0] scaled;
    logic               flt;
  } face_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [17:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] density = '0, mom_x = '0, mom_y = '0, mom_z = '0;
  logic signed [31:0] energy = '0, face_scale = '0;
  logic last_node = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [30:0] max_speed;
  logic signed [31:0] scaled_speed;
  logic range_fault;

  face_max_wave_speed u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .density(density), .mom_x(mom_x), .mom_y(mom_y), .mom_z(mom_z),
    .energy(energy), .face_scale(face_scale), .last_node(last_node),
    .out_valid(out_valid), .out_ready(out_ready),
    .max_speed(max_speed), .scaled_speed(scaled_speed), .range_fault(range_fault)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [47:0] peak_v2 = '0, peak_c2 = '0;
  logic face_fault = 1'b0;
  logic [17:0] gamma_reg = fmws_pkg::GAMMA_RESET;
  face_result_t face_results_q[$];

  int err_cnt = 0;
  int tx_idle_pct = 0, rx_idle_pct = 0;
  int stall_cnt = 0;
  int hold_cnt = 0;
  logic hold_tog = 1'b0, hold_seen = 1'b0;

  function automatic logic [32:0] mag32(logic [31:0] v);
    return v[31] ? 33'h1_0000_0000 - {1'b0, v} : {1'b0, v};
  endfunction

  function automatic logic [47:0] mul_down(logic [63:0] a, logic [63:0] b, int sh,
                                           inout logic f);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    if (p[127:64] != '0) begin
      f = 1'b1;
      return fmws_pkg::LIM;
    end
    p = p >> sh;
    if (p > 128'(fmws_pkg::LIM)) begin
      f = 1'b1;
      return fmws_pkg::LIM;
    end
    return p[47:0];
  endfunction

  function automatic logic [47:0] div_up(logic [63:0] num, logic [63:0] den, inout logic f);
    logic [63:0] q;
    if ((num >> (64 - FB)) != '0) begin
      f = 1'b1;
      return fmws_pkg::LIM;
    end
    q = (num << FB) / den;
    if (q > 64'(fmws_pkg::LIM)) begin
      f = 1'b1;
      return fmws_pkg::LIM;
    end
    return q[47:0];
  endfunction

  function automatic logic [31:0] root_fx(logic [47:0] x);
    logic [31:0] r;
    logic [31:0] c;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (32'd1 << b);
      if (((64'(c) * 64'(c)) >> FB) <= 64'(x)) r = c;
    end
    return r;
  endfunction

  // fold one node into the running maxima; close the face on the last node
  function automatic void predict_node(logic [31:0] rho_w, logic [31:0] mx, logic [31:0] my,
                                       logic [31:0] mz, logic [31:0] e, logic [31:0] fs,
                                       logic lst);
    logic f;
    logic [63:0] rho, v2, g1, s, fsm, prod;
    logic [47:0] ke, p, gp, c2;
    logic signed [63:0] d;
    logic [63:0] ad;
    face_result_t res;
    f = 1'b0;
    if (rho_w[31] || rho_w == '0) begin
      f = 1'b1;
      peak_v2 = fmws_pkg::LIM;
      peak_c2 = fmws_pkg::LIM;
    end else begin
      rho = 64'(rho_w);
      v2 = 64'(mul_down(64'(div_up(64'(mag32(mx)), rho, f)),
                        64'(div_up(64'(mag32(mx)), rho, f)), FB, f));
      v2 += 64'(mul_down(64'(div_up(64'(mag32(my)), rho, f)),
                         64'(div_up(64'(mag32(my)), rho, f)), FB, f));
      v2 += 64'(mul_down(64'(div_up(64'(mag32(mz)), rho, f)),
                         64'(div_up(64'(mag32(mz)), rho, f)), FB, f));
      if (v2 > 64'(fmws_pkg::LIM)) begin
        f = 1'b1;
        v2 = 64'(fmws_pkg::LIM);
      end
      ke = mul_down(rho, v2, FB + 1, f);
      d = $signed({{32{e[31]}}, e}) - $signed({16'd0, ke});
      ad = d < 0 ? 64'(-d) : 64'(d);
      g1 = gamma_reg >= 18'd65536 ? 64'(gamma_reg) - 64'd65536 : 64'd65536 - 64'(gamma_reg);
      p = mul_down(g1, ad, FB, f);
      gp = mul_down(64'(gamma_reg), 64'(p), FB, f);
      c2 = div_up(64'(gp), rho, f);
      if (v2[47:0] > peak_v2) peak_v2 = v2[47:0];
      if (c2 > peak_c2) peak_c2 = c2;
    end
    if (f) face_fault = 1'b1;
    if (!lst) return;
    s = 64'(root_fx(peak_v2)) + 64'(root_fx(peak_c2));
    res.flt = face_fault;
    if (s > 64'h7FFF_FFFF) begin
      s = 64'h7FFF_FFFF;
      res.flt = 1'b1;
    end
    fsm = 64'(mag32(fs));
    prod = (s * fsm) >> FB;
    if (fs[31]) begin
      if (prod > 64'h8000_0000) begin
        prod = 64'h8000_0000;
        res.flt = 1'b1;
      end
      prod = -prod;
    end else if (prod > 64'h7FFF_FFFF) begin
      prod = 64'h7FFF_FFFF;
      res.flt = 1'b1;
    end
    res.spd = s[30:0];
    res.scaled = prod[31:0];
    face_results_q.push_back(res);
    peak_v2 = '0;
    peak_c2 = '0;
    face_fault = 1'b0;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("ERROR @%0t: %s got %0h expected %0h", $realtime, what, got, want);
    err_cnt++;
  endtask

  // check each output transfer against the oldest expected face result
  always @(posedge clk) begin
    face_result_t w;
    if (!rst && out_valid && out_ready) begin
      if (face_results_q.size() == 0) begin
        report_mismatch("unexpected result, max_speed", max_speed, 0);
      end else begin
        w = face_results_q.pop_front();
        if (max_speed !== w.spd) report_mismatch("max_speed", max_speed, w.spd);
        if (scaled_speed !== w.scaled)
          report_mismatch("scaled_speed", scaled_speed, w.scaled);
        if (range_fault !== w.flt) report_mismatch("range_fault", range_fault, w.flt);
      end
    end
  end

  // receiver: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_tog != hold_seen) begin
      hold_seen <= hold_tog;
      hold_cnt <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("face_max_wave_speed verification failed");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // offer one node and hold it until the transfer
  task automatic send_node(logic [31:0] rho_w, logic [31:0] mx, logic [31:0] my,
                           logic [31:0] mz, logic [31:0] e, logic [31:0] fs, logic lst);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    density <= rho_w;
    mom_x <= mx;
    mom_y <= my;
    mom_z <= mz;
    energy <= e;
    face_scale <= fs;
    last_node <= lst;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_node(rho_w, mx, my, mz, e, fs, lst);
  endtask

  // drop valid, wait for all results, then let a pending node finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (face_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_gamma(logic [17:0] g);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= g;
    @(posedge clk);
    gamma_reg = g;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] pick_word();
    logic [31:0] v;
    case ($urandom_range(5))
      0: v = $urandom;
      1: v = $urandom_range(0, 1 << 17);
      2: v = $urandom_range(0, 1 << 24);
      3: begin
        case ($urandom_range(4))
          0: v = 32'h0;
          1: v = 32'h1;
          2: v = 32'h7FFF_FFFF;
          3: v = 32'h8000_0000;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      default: v = $urandom_range(0, 1 << 20);
    endcase
    if ($urandom_range(1)) v = -v;
    return v;
  endfunction

  task automatic test_field_extremes();
    send_node(32'h0001_0000, 32'h0000_8000, 32'hFFFF_C000, 32'h0, 32'h0002_8000,
              32'h0001_0000, 1'b1);
    send_node(32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 1'b1);
    send_node(32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_0000, 1'b1);
    send_node(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    send_node(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h7FFF_FFFF, 1'b1);
    send_node(32'h1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 1'b1);
    send_node(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 1'b1);
    send_node(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'hFFFE_0000, 1'b1);
    send_node(32'h0000_4000, 32'h0003_0000, 32'h0, 32'h0, 32'h0010_0000, 32'h0, 1'b0);
    send_node(32'h0002_0000, 32'h0, 32'hFFF0_0000, 32'h0, 32'hFF00_0000, 32'h0, 1'b0);
    send_node(32'h0000_0100, 32'h0, 32'h0, 32'h0001_0000, 32'h0000_1000, 32'h0000_8000, 1'b1);
  endtask

  task automatic test_gamma_settings();
    logic [17:0] gammas[6] = '{18'd65537, 18'd196608, 18'd0, 18'd32768, 18'h3FFFF,
                               fmws_pkg::GAMMA_RESET};
    foreach (gammas[i]) begin
      write_gamma(gammas[i]);
      send_node(32'h0001_0000, 32'h0000_8000, 32'h0, 32'h0, 32'h0003_0000, 32'h0001_0000, 1'b0);
      send_node(32'h0000_8000, 32'h0, 32'h0001_0000, 32'h0, 32'hFFFD_0000, 32'hFFFF_0000, 1'b1);
    end
  endtask

  task automatic test_random_faces(int n_nodes, int tx_pct, int rx_pct);
    int sent, len;
    logic noisy;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    while (sent < n_nodes) begin
      len = $urandom_range(1, 5);
      for (int k = 0; k < len; k++) begin
        noisy = ($urandom_range(99) < 15);
        send_node(noisy ? pick_word() : 32'($urandom_range(1 << 12, 1 << 22)),
                  pick_word(), pick_word(), pick_word(),
                  noisy ? pick_word() : 32'($urandom_range(0, 1 << 26)),
                  pick_word(), k == len - 1);
        sent++;
      end
    end
  endtask

  // hold the receiver off so the output register fills and input stalls
  task automatic test_backpressure();
    tx_idle_pct = 0;
    hold_tog <= ~hold_tog;
    for (int k = 0; k < 8; k++)
      send_node(32'($urandom_range(1 << 14, 1 << 20)), pick_word(), pick_word(), pick_word(),
                32'($urandom_range(0, 1 << 24)), pick_word(), 1'b1);
  endtask

  task automatic test_sender_pause();
    for (int k = 0; k < 3; k++)
      send_node(32'h0001_0000, pick_word(), pick_word(), pick_word(), 32'h0004_0000,
                32'h0001_0000, k == 2);
    in_valid <= 1'b0;
    while (face_results_q.size() != 0) @(posedge clk);
    send_node(32'h0002_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 32'hFFFF_8000, 1'b1);
  endtask

  initial begin
    rx_idle_pct = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_field_extremes();
    test_gamma_settings();
    test_random_faces(520, 24, 83);
    test_backpressure();
    test_sender_pause();
    write_gamma(18'd196608);
    test_random_faces(520, 83, 24);
    write_gamma(18'd65537);
    test_random_faces(500, 0, 0);
    wait_idle();
    if (err_cnt == 0) begin
      $display("face_max_wave_speed verification clean");
    end else begin
      $display("face_max_wave_speed verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
